### hdl/gre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gear rpm speed estimator package
// Shared widths, register indexes, item codes, state types and the request
// and response records of the raw speed unit.
// ----------------------------------------------------------------------------
package gre_pkg;

  localparam int RPM_W   = 16;
  localparam int GEAR_W  = 4;
  localparam int RATIO_W = 16;
  localparam int CIRC_W  = 13;
  localparam int SPEED_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int NUM_RATIO = 6;

  // Datapath widths of the raw speed unit.
  localparam int PROD_W   = RPM_W + CIRC_W;   // rpm * circumference
  localparam int TRIPLE_W = PROD_W + 2;       // times three
  localparam int DEN_W    = RATIO_W + 7;      // ratio * 100
  localparam int Q_W      = 32;               // Q16.16 raw speed
  localparam int CNT_W    = 5;

  // Filter gain and its serial multiplier.
  localparam int GAIN_W = 17;
  localparam int FACC_W = Q_W + GAIN_W;

  localparam logic [GAIN_W-1:0]  SMOOTHING_Q16 = 17'd16384;
  localparam logic [15:0]        SETTLE_MS     = 16'd300;
  localparam logic [Q_W-1:0]     RAW_MIN_Q16   = 32'h0001_0000;
  localparam logic [Q_W-1:0]     RAW_MAX_Q16   = 32'hFFFF_FFFF;

  localparam logic [RATIO_W-1:0] RATIO_RESET      = 16'd1024;
  localparam logic [RATIO_W-1:0] FINAL_LOW_RESET  = 16'd4096;
  localparam logic [CIRC_W-1:0]  TIRE_CIRC_RESET  = 13'd1950;

  localparam logic [IDX_W-1:0] REG_RATIO_G1  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FINAL_LOW = 3'd6;
  localparam logic [IDX_W-1:0] REG_TIRE_CIRC = 3'd7;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [2:0] {
    T_IDLE,
    T_RAW,
    T_FMUL,
    T_FUPD,
    T_FRND,
    T_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_MUL,
    R_TRIPLE,
    R_PREP,
    R_DIV,
    R_DONE
  } raw_state_t;

  typedef struct packed {
    logic               start;
    logic [RPM_W-1:0]   rpm;
    logic [CIRC_W-1:0]  circ;
    logic [RATIO_W-1:0] ratio;
  } raw_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] raw;
  } raw_rsp_t;

endpackage
`default_nettype wire

### hdl/gre_raw.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Raw speed unit
// Computes rpm * circumference * 0.06 / ratio in Q16.16 with a bit-serial
// multiplier and a one-bit-per-cycle restoring divider; a raw speed of at most
// 10 km/h is reported as 1 km/h, and the result is saturated to 32 bits.
// ----------------------------------------------------------------------------
module gre_raw (
  input  wire               clk,
  input  wire               rst,
  input  wire gre_pkg::raw_req_t req,
  output gre_pkg::raw_rsp_t rsp
);
  import gre_pkg::*;

  raw_state_t state, state_next;

  logic [TRIPLE_W-1:0] acc;
  logic [PROD_W-1:0]   mcand;
  logic [CIRC_W-1:0]   mplier;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    rem;
  logic [Q_W-1:0]      q;
  logic [CNT_W-1:0]    cnt;

  logic [RATIO_W-1:0]  ratio_eff;
  logic [DEN_W-1:0]    den_in;
  logic [TRIPLE_W-1:0] triple;
  logic                is_low;
  logic                is_ovf;
  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      trial_sub;
  logic                trial_ge;

  always_comb begin
    ratio_eff = (req.ratio == '0) ? RATIO_W'(1) : req.ratio;
    den_in    = DEN_W'({ratio_eff, 6'b0}) + DEN_W'({ratio_eff, 5'b0})
              + DEN_W'({ratio_eff, 2'b0});
    triple    = acc + {acc[TRIPLE_W-2:0], 1'b0};
    // The exact raw speed is at most 10 km/h when 3 * product * 1024 <= 500 * ratio.
    is_low    = {acc, 10'b0} <= (TRIPLE_W+10)'({den, 2'b0}) + (TRIPLE_W+10)'(den);
    // The quotient needs more than 32 bits when 3 * product >= 32 * den.
    is_ovf    = acc >= TRIPLE_W'({den, 5'b0});
    trial     = {rem, q[Q_W-1]};
    trial_ge  = trial >= {1'b0, den};
    trial_sub = trial - {1'b0, den};
  end

  always_comb begin
    state_next = state;
    case (state)
      R_IDLE: begin
        if (req.start) begin
          state_next = R_MUL;
        end
      end
      R_MUL: begin
        if (cnt == CNT_W'(CIRC_W - 1)) begin
          state_next = R_TRIPLE;
        end
      end
      R_TRIPLE: state_next = R_PREP;
      R_PREP: begin
        state_next = (is_low || is_ovf) ? R_DONE : R_DIV;
      end
      R_DIV: begin
        if (cnt == CNT_W'(Q_W - 1)) begin
          state_next = R_DONE;
        end
      end
      R_DONE: state_next = R_IDLE;
      default: state_next = R_IDLE;
    endcase
    rsp.done = (state == R_DONE);
    rsp.raw  = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      R_IDLE: begin
        if (req.start) begin
          acc    <= '0;
          mcand  <= PROD_W'(req.rpm);
          mplier <= req.circ;
          den    <= den_in;
          cnt    <= '0;
        end
      end
      R_MUL: begin
        if (mplier[0]) begin
          acc <= acc + TRIPLE_W'(mcand);
        end
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[CIRC_W-1:1]};
        cnt    <= cnt + 1'b1;
      end
      R_TRIPLE: acc <= triple;
      R_PREP: begin
        if (is_low) begin
          q <= RAW_MIN_Q16;
        end else if (is_ovf) begin
          q <= RAW_MAX_Q16;
        end else begin
          rem <= acc[DEN_W+4:5];
          q   <= {acc[4:0], 27'b0};
          cnt <= '0;
        end
      end
      R_DIV: begin
        rem <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        q   <= {q[Q_W-2:0], trial_ge};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == R_DIV) |-> (rem < den))
    else $error("Divider remainder is not below the divisor.");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == R_MUL) |-> (cnt < CNT_W'(CIRC_W)))
    else $error("Multiplier ran past the multiplier width.");
`endif

endmodule
`default_nettype wire

### hdl/gear_rpm_speed_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gear rpm speed estimator
// Road speed from engine rpm and engaged gear, low-pass filtered, with a
// settle hold after gear changes counted by tick items.
// ----------------------------------------------------------------------------
// A tick item, or a sample that does not run the filter, goes straight to the
// output load once it is accepted. A sample that runs the filter passes through
// the serial rpm times circumference multiply, the tripling of the product and
// the divider setup, the restoring divider that retires one quotient bit a
// cycle, the hand-over of the raw speed, the serial gain multiply, and then the
// update, the rounding and the output load. When the raw speed sits at the
// 1 km/h floor or saturates, the divider is skipped. One item is worked on at a
// time, and the next one is taken the cycle after the result is loaded; the
// output register lets the next item in while a result still waits to be taken.
module gear_rpm_speed_estimator (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_write,
  input  wire  [gre_pkg::IDX_W-1:0]   cfg_index,
  input  wire  [gre_pkg::CFG_W-1:0]   cfg_data,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         op,
  input  wire  [gre_pkg::RPM_W-1:0]   rpm,
  input  wire  [gre_pkg::GEAR_W-1:0]  gear_now,
  input  wire                         lever_drive,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [gre_pkg::SPEED_W-1:0] speed_kmh
);
  import gre_pkg::*;

  logic [RATIO_W-1:0] ratio [NUM_RATIO];
  logic [RATIO_W-1:0] final_low;
  logic [CIRC_W-1:0]  tire_circ;

  top_state_t state, state_next;

  logic [GEAR_W-1:0]  prev_gear;
  logic [15:0]        settle_left;
  logic [Q_W-1:0]     filtered;
  logic [SPEED_W-1:0] speed_out;

  logic               fneg;
  logic [FACC_W-1:0]  facc;
  logic [FACC_W-1:0]  fmcand;
  logic [GAIN_W-1:0]  fmplier;
  logic [CNT_W-1:0]   fcnt;

  raw_req_t           req;
  raw_rsp_t           rsp;

  logic               accept;
  logic               gear_changed;
  logic [15:0]        settle_eff;
  logic               sample_drive;
  logic               run;
  logic [RATIO_W-1:0] ratio_sel;
  logic               raw_below;
  logic [Q_W-1:0]     diff_mag;
  logic [FACC_W-1:0]  facc_ceil;
  logic [Q_W:0]       rnd;
  logic               out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_RATIO; i++) begin
        ratio[i] <= RATIO_RESET;
      end
      final_low <= FINAL_LOW_RESET;
      tire_circ <= TIRE_CIRC_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FINAL_LOW: final_low <= cfg_data;
        REG_TIRE_CIRC: tire_circ <= cfg_data[CIRC_W-1:0];
        default:       ratio[cfg_index - REG_RATIO_G1] <= cfg_data;
      endcase
    end
  end

  always_comb begin
    accept       = in_valid && !in_stall;
    gear_changed = (gear_now != prev_gear);
    settle_eff   = gear_changed ? SETTLE_MS : settle_left;
    sample_drive = (op == OP_SAMPLE) && (gear_now != '0) && (rpm != '0) && lever_drive;
    run          = sample_drive && (settle_eff == '0);
    if ((gear_now >= GEAR_W'(1)) && (gear_now <= GEAR_W'(NUM_RATIO))) begin
      ratio_sel = ratio[gear_now[IDX_W-1:0] - IDX_W'(1)];
    end else begin
      ratio_sel = final_low;
    end
    req.start = accept && run;
    req.rpm   = rpm;
    req.circ  = tire_circ;
    req.ratio = ratio_sel;
    raw_below = rsp.raw < filtered;
    diff_mag  = raw_below ? (filtered - rsp.raw) : (rsp.raw - filtered);
    facc_ceil = facc + FACC_W'(16'hFFFF);
    rnd       = {1'b0, filtered} + (Q_W+1)'(32'h8000);
    out_load  = (state == T_DONE) && (!out_valid || !out_stall);
  end

  gre_raw u_raw (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    state_next = state;
    in_stall   = (state != T_IDLE);
    case (state)
      T_IDLE: begin
        if (in_valid) begin
          state_next = run ? T_RAW : T_DONE;
        end
      end
      T_RAW: begin
        if (rsp.done) begin
          state_next = T_FMUL;
        end
      end
      T_FMUL: begin
        if (fcnt == CNT_W'(GAIN_W - 1)) begin
          state_next = T_FUPD;
        end
      end
      T_FUPD: state_next = T_FRND;
      T_FRND: state_next = T_DONE;
      T_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      prev_gear   <= '0;
      settle_left <= '0;
      filtered    <= '0;
      speed_out   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (op == OP_TICK) begin
          if (settle_left != '0) begin
            settle_left <= settle_left - 1'b1;
          end
        end else if (gear_now == '0) begin
          filtered  <= '0;
          speed_out <= '0;
        end else if (rpm != '0) begin
          if (lever_drive) begin
            prev_gear   <= gear_now;
            settle_left <= settle_eff;
          end else begin
            filtered  <= '0;
            speed_out <= '0;
          end
        end
      end
      if (state == T_FUPD) begin
        if (fneg) begin
          filtered <= filtered - facc_ceil[Q_W+15:16];
        end else begin
          filtered <= filtered + facc[Q_W+15:16];
        end
      end
      if (state == T_FRND) begin
        speed_out <= rnd[Q_W] ? '1 : rnd[Q_W-1:16];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      speed_kmh <= speed_out;
    end
    case (state)
      T_RAW: begin
        if (rsp.done) begin
          fneg    <= raw_below;
          facc    <= '0;
          fmcand  <= FACC_W'(diff_mag);
          fmplier <= SMOOTHING_Q16;
          fcnt    <= '0;
        end
      end
      T_FMUL: begin
        if (fmplier[0]) begin
          facc <= facc + fmcand;
        end
        fmcand  <= {fmcand[FACC_W-2:0], 1'b0};
        fmplier <= {1'b0, fmplier[GAIN_W-1:1]};
        fcnt    <= fcnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_start_goes_raw: assert property (@(posedge clk) disable iff (rst)
    (accept && run) |=> (state == T_RAW))
    else $error("A filtered sample did not start the raw speed unit.");

  a_done_in_raw: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == T_RAW))
    else $error("Raw speed result arrived outside the wait state.");

  a_settle_bound: assert property (@(posedge clk) disable iff (rst)
    settle_left <= SETTLE_MS)
    else $error("Settle countdown exceeds its load value.");

  a_zero_filter_zero_speed: assert property (@(posedge clk) disable iff (rst)
    ((state != T_FRND) && (filtered == '0)) |-> (speed_out == '0))
    else $error("Speed is nonzero while the filter is cleared.");
`endif

endmodule
`default_nettype wire

### test/gear_rpm_speed_estimator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gear rpm speed estimator testbench
// Drives rpm samples and millisecond ticks through several ratio and tire
// settings under random sender gaps and receiver stalls. A scoreboard keeps
// its own copy of the filter, the settle countdown and the registers, works
// out the speed each accepted item should report, and checks the results in
// order.
// ----------------------------------------------------------------------------
module gear_rpm_speed_estimator_tb;
  import gre_pkg::*;

  typedef logic [CFG_W-1:0] reg_set_t [8];

  class speed_scoreboard;
    logic [RATIO_W-1:0] ratio_q10 [NUM_RATIO];
    logic [RATIO_W-1:0] final_low_q10;
    logic [CIRC_W-1:0]  tire_circ;
    logic [GEAR_W-1:0]  prev_gear;
    logic [15:0]        settle_left;
    logic [Q_W-1:0]     filt_q16;
    logic [SPEED_W-1:0] speed_out;
    logic [SPEED_W-1:0] expected_speed [$];
    int                 errors;

    function new();
      foreach (ratio_q10[i]) ratio_q10[i] = RATIO_RESET;
      final_low_q10 = FINAL_LOW_RESET;
      tire_circ = TIRE_CIRC_RESET;
      prev_gear = '0;
      settle_left = '0;
      filt_q16 = '0;
      speed_out = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_FINAL_LOW: final_low_q10 = data;
        REG_TIRE_CIRC: tire_circ = data[CIRC_W-1:0];
        default: ratio_q10[idx - REG_RATIO_G1] = data;
      endcase
    endfunction

    // Raw km/h in Q16.16: rpm * circ * 0.06 / ratio, with 0.06 * 1024 = 6144 / 100.
    function logic [Q_W-1:0] raw_kmh_q16(logic [RPM_W-1:0] rpm_v, logic [GEAR_W-1:0] gear_v);
      logic [63:0] ratio_v;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quot;
      if (gear_v >= 1 && gear_v <= NUM_RATIO) ratio_v = 64'(ratio_q10[gear_v - 1]);
      else ratio_v = 64'(final_low_q10);
      if (ratio_v == 0) ratio_v = 64'd1;
      num = 64'(rpm_v) * 64'(tire_circ) * 64'd6144 * 64'd65536;
      den = 64'd100 * ratio_v;
      if (num <= 64'd655360 * den) return RAW_MIN_Q16;
      quot = num / den;
      if (quot > 64'(RAW_MAX_Q16)) return RAW_MAX_Q16;
      return quot[Q_W-1:0];
    endfunction

    function void smooth_speed(logic [Q_W-1:0] raw);
      longint f;
      longint diff;
      longint gain;
      longint delta;
      longint rounded;
      f = longint'({32'b0, filt_q16});
      diff = longint'({32'b0, raw}) - f;
      gain = longint'(SMOOTHING_Q16);
      if (gain > 65536) gain = 65536;
      if (diff >= 0) delta = (diff * gain) >>> 16;
      else delta = -(((-diff) * gain + 65535) >>> 16);
      f = f + delta;
      if (f < 0) f = 0;
      if (f > 64'sh0000_0000_FFFF_FFFF) f = 64'sh0000_0000_FFFF_FFFF;
      filt_q16 = f[31:0];
      rounded = (f + 32768) >>> 16;
      if (rounded > 65535) speed_out = '1;
      else speed_out = rounded[15:0];
    endfunction

    function void note_item(logic op_v, logic [RPM_W-1:0] rpm_v, logic [GEAR_W-1:0] gear_v,
                            logic drive_v);
      if (op_v == OP_TICK) begin
        if (settle_left != 0) settle_left = settle_left - 1'b1;
      end else if (gear_v == 0) begin
        speed_out = '0;
        filt_q16 = '0;
      end else if (rpm_v != 0) begin
        if (drive_v) begin
          if (gear_v != prev_gear) begin
            prev_gear = gear_v;
            settle_left = SETTLE_MS;
          end
          if (settle_left == 0) smooth_speed(raw_kmh_q16(rpm_v, gear_v));
        end else begin
          speed_out = '0;
          filt_q16 = '0;
        end
      end
      expected_speed.push_back(speed_out);
    endfunction

    function void log_error(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(logic [SPEED_W-1:0] got);
      logic [SPEED_W-1:0] want;
      if (expected_speed.size() == 0) begin
        log_error($sformatf("speed %0d arrived with no item outstanding", got));
      end else begin
        want = expected_speed.pop_front();
        if (got !== want)
          log_error($sformatf("speed_kmh mismatch: expected %0d, got %0d", want, got));
      end
    endfunction

    function int pending();
      return expected_speed.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 op = OP_SAMPLE;
  logic [RPM_W-1:0]     rpm = '0;
  logic [GEAR_W-1:0]    gear_now = '0;
  logic                 lever_drive = 1'b0;
  logic                 out_stall = 1'b0;
  wire                  in_stall;
  wire                  out_valid;
  wire  [SPEED_W-1:0]   speed_kmh;

  speed_scoreboard      sb;
  int                   gap_pct = 0;
  int                   stall_pct = 0;
  int                   hold_off_left = 0;
  logic [GEAR_W-1:0]    cur_gear = '0;

  gear_rpm_speed_estimator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .rpm         (rpm),
    .gear_now    (gear_now),
    .lever_drive (lever_drive),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .speed_kmh   (speed_kmh)
  );

  always #2 clk = ~clk;

  task automatic send_item(input logic op_v, input logic [RPM_W-1:0] rpm_v,
                           input logic [GEAR_W-1:0] gear_v, input logic drive_v);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_v;
    rpm <= rpm_v;
    gear_now <= gear_v;
    lever_drive <= drive_v;
    do @(posedge clk); while (in_stall);
    sb.note_item(op_v, rpm_v, gear_v, drive_v);
    if (op_v == OP_SAMPLE && drive_v && gear_v != 0 && rpm_v != 0) cur_gear = gear_v;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input reg_set_t vals);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_RATIO_G1 + IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(REG_RATIO_G1 + IDX_W'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [RPM_W-1:0] pick_rpm();
    case ($urandom_range(9))
      0: return RPM_W'($urandom_range(0, 20));
      1: return RPM_W'($urandom_range(65500, 65535));
      2, 3: return RPM_W'($urandom());
      default: return RPM_W'($urandom_range(600, 7000));
    endcase
  endfunction

  function automatic logic [RPM_W-1:0] pick_running_rpm();
    logic [RPM_W-1:0] r;
    r = pick_rpm();
    if (r == 0) r = 1;
    return r;
  endfunction

  // Ticks count the settle hold down; the odd sample in between is held while the hold is still running.
  task automatic tick_burst(input int n);
    repeat (n) begin
      if ($urandom_range(19) == 0) send_item(OP_SAMPLE, pick_running_rpm(), cur_gear, 1'b1);
      send_item(OP_TICK, RPM_W'($urandom()), GEAR_W'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic shift_gear(input logic [GEAR_W-1:0] gear_v, input logic full);
    send_item(OP_SAMPLE, pick_running_rpm(), gear_v, 1'b1);
    if (full) tick_burst(int'(SETTLE_MS) + $urandom_range(0, 3));
    else tick_burst($urandom_range(1, 30));
  endtask

  task automatic run_random(input int episodes);
    int pick;
    int run_len;
    logic [GEAR_W-1:0] g;
    logic [RPM_W-1:0] r;
    repeat (episodes) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        do g = GEAR_W'($urandom_range(1, 15)); while (g == cur_gear);
        shift_gear(g, 1'b0);
      end else if (pick < 12) begin
        run_len = $urandom_range(1, 40);
        r = pick_running_rpm();
        repeat (run_len) send_item(OP_SAMPLE, r, cur_gear, 1'b1);
      end else if (pick < 60) begin
        send_item(OP_SAMPLE, pick_rpm(), cur_gear, 1'b1);
      end else if (pick < 75) begin
        send_item(OP_TICK, RPM_W'($urandom()), GEAR_W'($urandom()), 1'($urandom()));
      end else if (pick < 80) begin
        send_item(OP_SAMPLE, pick_rpm(), '0, 1'($urandom()));
      end else if (pick < 87) begin
        send_item(OP_SAMPLE, pick_rpm(), GEAR_W'($urandom()), 1'b0);
      end else if (pick < 94) begin
        send_item(OP_SAMPLE, '0, GEAR_W'($urandom_range(1, 15)), 1'($urandom()));
      end else if (pick < 97) begin
        send_item(OP_SAMPLE, pick_running_rpm(), GEAR_W'($urandom_range(1, 15)), 1'b1);
      end else begin
        send_item(1'($urandom()), RPM_W'($urandom()), GEAR_W'($urandom()), 1'($urandom()));
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(speed_kmh);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values, sender gaps light and receiver stalls heavy.
    gap_pct = 16;
    stall_pct = 58;
    send_item(OP_TICK, '1, '1, 1'b1);
    send_item(OP_SAMPLE, 16'hFFFF, '0, 1'b1);
    send_item(OP_SAMPLE, '0, 4'd5, 1'b1);
    send_item(OP_SAMPLE, '0, 4'd5, 1'b0);
    send_item(OP_SAMPLE, 16'd4000, 4'd15, 1'b0);
    send_item(OP_SAMPLE, 16'hFFFF, 4'd5, 1'b1);
    send_item(OP_SAMPLE, 16'd3000, 4'd5, 1'b1);
    tick_burst(int'(SETTLE_MS));
    repeat (8) send_item(OP_SAMPLE, 16'hFFFF, 4'd5, 1'b1);
    send_item(OP_SAMPLE, 16'd1, 4'd5, 1'b1);
    send_item(OP_TICK, '0, '0, 1'b0);
    send_item(OP_SAMPLE, 16'd2500, '0, 1'b0);
    send_item(OP_SAMPLE, 16'd1, 4'd5, 1'b1);
    send_item(OP_SAMPLE, 16'd2000, 4'd5, 1'b0);
    send_item(OP_SAMPLE, 16'd3500, 4'd5, 1'b1);
    run_random(10);

    // Typical ratios; gear two and this tire put rpm 1 exactly on 10 km/h.
    drain();
    program_regs('{16'd3000, 16'd6144, 16'd1800, 16'd1300, 16'd1000, 16'd800,
                   16'd9000, 16'd1000});
    gap_pct = 58;
    stall_pct = 16;
    shift_gear(4'd2, 1'b1);
    send_item(OP_SAMPLE, 16'd1, 4'd2, 1'b1);
    send_item(OP_SAMPLE, 16'd2, 4'd2, 1'b1);
    run_random(10);

    // Extreme ratios, a zero ratio and an oversized tire write.
    drain();
    program_regs('{16'd1, 16'hFFFF, 16'd0, 16'd1024, 16'd2, 16'hFFFE, 16'hFFFF, 16'hFFFF});
    gap_pct = 0;
    stall_pct = 0;
    shift_gear(4'd1, 1'b1);
    hold_off_left = 600;
    repeat (20) send_item(OP_SAMPLE, 16'hFFFF, 4'd1, 1'b1);
    run_random(10);

    // Random ratios, smallest final drive and tire.
    drain();
    program_regs('{16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   16'd1, 16'hE001});
    gap_pct = 0;
    stall_pct = 0;
    shift_gear(4'd12, 1'b1);
    run_random(5);
    drain();
    run_random(5);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
